### design/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and the tempering function of the MT19937 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

    localparam int unsigned N_WORDS     = 624;
    localparam int unsigned M_OFFSET    = 397;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned CMD_DEPTH   = 2;

    localparam logic [31:0] INIT_MUL    = 32'd1812433253;
    localparam logic [31:0] MATRIX_A    = 32'h9908_b0df;
    localparam logic [31:0] UPPER_MASK  = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B    = 32'd2636928640;
    localparam logic [31:0] TEMPER_C    = 32'd4022730752;

    typedef struct packed {
        logic need_fill;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEED,
        B_MUL,
        B_ADD,
        B_READ,
        B_EXEC
    } t_back_state;

    function automatic logic [31:0] temper(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & TEMPER_B);
        w = w ^ ((w << 15) & TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

endpackage

`default_nettype wire

### design/mtg_front.sv
// ----------------------------------------------------------------------------
// mtg_front
// Accepts requests and classifies each as fill-then-generate or generate.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_front (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire          i_reseed,
    input  wire          i_q_full,
    output logic         o_full,
    output logic         o_q_push,
    output mtg_pkg::t_cmd o_cmd
);

    logic r_seeded;
    logic n_seeded;

    assign o_full        = i_q_full;
    assign o_q_push      = i_push & ~i_q_full;
    assign o_cmd.need_fill = i_reseed | ~r_seeded;

    always_comb begin
        n_seeded = r_seeded | o_q_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else begin
            r_seeded <= n_seeded;
        end
    end

endmodule

`default_nettype wire

### design/mtg_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mtg_cmd_fifo
// Short command queue between the request front and the generator back.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_cmd_fifo #(
    parameter int unsigned DEPTH = mtg_pkg::CMD_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  mtg_pkg::t_cmd i_cmd,
    input  wire           i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mtg_pkg::t_cmd o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mtg_pkg::t_cmd r_store [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          push_fire;
    logic          pop_fire;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_cmd     = r_store[r_rd_ptr];
    assign push_fire = i_push & ~o_full;
    assign pop_fire  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_fire) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_fire) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            n_count = r_count + 1'b1;
        end else if (pop_fire && !push_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_store[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### design/mtg_back.sv
// ----------------------------------------------------------------------------
// mtg_back
// State memory, seeding sequencer, incremental twist, tempering and result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_back (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire  [31:0]   i_seed,
    input  wire           i_q_empty,
    input  mtg_pkg::t_cmd i_cmd,
    output logic          o_q_pop,
    output logic          o_empty,
    input  wire           i_pop,
    output logic [31:0]   o_random_word
);

    localparam int unsigned IW = mtg_pkg::IDX_W;

    logic [31:0]          mem [0:mtg_pkg::N_WORDS-1];

    mtg_pkg::t_back_state r_state;
    mtg_pkg::t_back_state n_state;
    logic [IW-1:0]        r_pos;
    logic [IW-1:0]        n_pos;
    logic [IW-1:0]        r_fidx;
    logic [IW-1:0]        n_fidx;
    logic [31:0]          r_prev;
    logic [31:0]          n_prev;
    logic [31:0]          r_prod;
    logic [31:0]          n_prod;
    logic [31:0]          r_cur;
    logic [31:0]          n_cur;
    logic [31:0]          r_rd_next;
    logic [31:0]          r_rd_far;
    logic [31:0]          r_out;
    logic [31:0]          n_out;
    logic                 r_out_valid;
    logic                 n_out_valid;

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [31:0]          mem_wdata;
    logic                 mem_re;
    logic [IW-1:0]        addr_next;
    logic [IW-1:0]        addr_far;
    logic [IW:0]          far_sum;
    logic [31:0]          fill_word;
    logic [31:0]          mix;
    logic [31:0]          twisted;
    logic [31:0]          prev_mixed;
    logic                 out_free;
    logic                 out_load;

    assign o_empty       = ~r_out_valid;
    assign o_random_word = r_out;
    assign out_free      = ~r_out_valid | i_pop;

    assign far_sum    = {1'b0, r_pos} + (IW + 1)'(mtg_pkg::M_OFFSET);
    assign addr_far   = (far_sum >= (IW + 1)'(mtg_pkg::N_WORDS))
                        ? IW'(far_sum - (IW + 1)'(mtg_pkg::N_WORDS)) : IW'(far_sum);
    assign addr_next  = (r_pos == IW'(mtg_pkg::N_WORDS - 1)) ? '0 : r_pos + 1'b1;
    assign prev_mixed = r_prev ^ (r_prev >> 30);
    assign fill_word  = r_prod + {{(32 - IW){1'b0}}, r_fidx};
    assign mix        = (r_cur & mtg_pkg::UPPER_MASK) | (r_rd_next & mtg_pkg::LOWER_MASK);
    assign twisted    = r_rd_far ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::MATRIX_A : 32'd0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtg_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_cmd.need_fill ? mtg_pkg::B_SEED : mtg_pkg::B_READ;
                end
            end
            mtg_pkg::B_SEED: n_state = mtg_pkg::B_MUL;
            mtg_pkg::B_MUL:  n_state = mtg_pkg::B_ADD;
            mtg_pkg::B_ADD: begin
                n_state = (r_fidx == IW'(mtg_pkg::N_WORDS - 1)) ? mtg_pkg::B_READ
                                                                  : mtg_pkg::B_MUL;
            end
            mtg_pkg::B_READ: n_state = mtg_pkg::B_EXEC;
            mtg_pkg::B_EXEC: begin
                if (out_free) begin
                    n_state = mtg_pkg::B_IDLE;
                end
            end
            default: n_state = mtg_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = twisted;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            mtg_pkg::B_IDLE: o_q_pop = ~i_q_empty;
            mtg_pkg::B_SEED: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = i_seed;
            end
            mtg_pkg::B_ADD: begin
                mem_we    = 1'b1;
                mem_waddr = r_fidx;
                mem_wdata = fill_word;
            end
            mtg_pkg::B_READ: mem_re = 1'b1;
            mtg_pkg::B_EXEC: begin
                mem_we   = out_free;
                out_load = out_free;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_pos       = r_pos;
        n_fidx      = r_fidx;
        n_prev      = r_prev;
        n_prod      = r_prod;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_pop;
        case (r_state)
            mtg_pkg::B_SEED: begin
                n_prev = i_seed;
                n_cur  = i_seed;
                n_fidx = IW'(1);
                n_pos  = '0;
            end
            mtg_pkg::B_MUL: n_prod = mtg_pkg::INIT_MUL * prev_mixed;
            mtg_pkg::B_ADD: begin
                n_prev = fill_word;
                n_fidx = r_fidx + 1'b1;
            end
            mtg_pkg::B_EXEC: begin
                if (out_load) begin
                    n_out       = mtg_pkg::temper(twisted);
                    n_out_valid = 1'b1;
                    n_cur       = r_rd_next;
                    n_pos       = addr_next;
                end
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtg_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fidx <= n_fidx;
        r_prev <= n_prev;
        r_prod <= n_prod;
        r_cur  <= n_cur;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_next <= mem[addr_next];
            r_rd_far  <= mem[addr_far];
        end
    end

endmodule

`default_nettype wire

### design/mt19937_generator_top.sv
// ----------------------------------------------------------------------------
// mt19937_generator_top
// MT19937 32-bit pseudo-random word generator with queue-style ports.
// ----------------------------------------------------------------------------
// Each accepted push returns one tempered word on the result side. The state
// array sits in a 624-word memory with one write and two read ports, and is
// twisted one word per request, one request at a time. A plain request passes
// through the idle step, which pops the command, a memory read step and a
// twist/write/temper step, which waits while an unpopped word is held. The
// first request after reset, and every request with reseed set, first
// refills the array from the seed register: a seed write, then a multiply
// step and an add step per word, sharing the memory write port one word at a
// time. A two-entry command queue lets requests be taken while the generator
// works, and a result register lets the next word be computed while the
// current one waits. Seed writes take effect at the next refill.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_generator_top #(
    parameter int unsigned CMD_DEPTH = mtg_pkg::CMD_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire         i_reseed,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_random_word,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_seed
);

    logic          r_seed;
    logic [31:0]   r_seed_word;
    logic [31:0]   n_seed_word;
    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    mtg_pkg::t_cmd front_cmd;
    mtg_pkg::t_cmd back_cmd;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_seed_word = r_seed_word;
        if (i_cfg_valid && o_cfg_ready) begin
            n_seed_word = i_cfg_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_word <= '0;
            r_seed      <= 1'b0;
        end else begin
            r_seed_word <= n_seed_word;
            r_seed      <= r_seed | (i_cfg_valid & o_cfg_ready);
        end
    end

    mtg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_reseed (i_reseed),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    mtg_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (back_cmd)
    );

    mtg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed        (r_seed ? r_seed_word : 32'd0),
        .i_q_empty     (q_empty),
        .i_cmd         (back_cmd),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_random_word (o_random_word)
    );

endmodule

`default_nettype wire

### sim/tb_mt19937_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mt19937_generator_top
// Self-checking testbench for the MT19937 word generator.
// ----------------------------------------------------------------------------
// Requests go in through the push/full side. An own model of the generator
// (seed shadow, 624-word state, read position) predicts one tempered word per
// accepted request. A checker compares every popped word with the oldest
// prediction. The run covers the implicit refill after reset, reseeds at
// extreme seeds, seed writes that wait for the next refill, a run across the
// second twist, a long output stall that fills the block, and random traffic
// with bursts of idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mt19937_generator_top;

    localparam int          CLK_PERIOD       = 20;
    localparam int          LIMIT_NS         = 20_000_000;
    localparam int          LONG_HOLD_CYCLES = 200;
    localparam int unsigned MT_WORDS         = 624;
    localparam int unsigned MT_SHIFT         = 397;
    localparam logic [31:0] SEED_MUL         = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR        = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT         = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS         = 32'h7fff_ffff;
    localparam logic [31:0] SHAPE_B          = 32'h9d2c_5680;
    localparam logic [31:0] SHAPE_C          = 32'hefc6_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_reseed;
    logic        empty;
    logic        pop;
    logic [31:0] o_random_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_seed;

    // model state
    logic [31:0] seed_shadow;
    logic [31:0] mt_words [0:MT_WORDS-1];
    int unsigned mt_pos;
    bit          mt_seeded;

    logic [31:0] pending_words [$];

    bit rst_done      = 1'b0;
    bit src_idle_en   = 1'b0;
    bit sink_idle_en  = 1'b0;
    bit long_hold_req = 1'b0;

    int err_count     = 0;
    int n_requests    = 0;
    int n_refills     = 0;
    int n_checked     = 0;
    int n_seed_writes = 0;
    int n_full_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    mt19937_generator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_reseed      (i_reseed),
        .empty         (empty),
        .pop           (pop),
        .o_random_word (o_random_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_seed    (i_cfg_seed)
    );

    function automatic void refill_words();
        logic [31:0] prev;
        mt_words[0] = seed_shadow;
        for (int unsigned k = 1; k < MT_WORDS; k++) begin
            prev        = mt_words[k-1];
            mt_words[k] = SEED_MUL * (prev ^ (prev >> 30)) + 32'(k);
        end
        mt_pos    = MT_WORDS;
        mt_seeded = 1'b1;
        n_refills++;
    endfunction

    function automatic void twist_words();
        logic [31:0] mix;
        for (int unsigned k = 0; k < MT_WORDS; k++) begin
            mix = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % MT_WORDS] & LOW_BITS);
            mt_words[k] = mt_words[(k + MT_SHIFT) % MT_WORDS] ^ (mix >> 1)
                          ^ (mix[0] ? TWIST_XOR : 32'h0);
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] shape_word(input logic [31:0] raw);
        logic [31:0] y;
        y = raw ^ (raw >> 11);
        y = y ^ ((y << 7) & SHAPE_B);
        y = y ^ ((y << 15) & SHAPE_C);
        return y ^ (y >> 18);
    endfunction

    function automatic logic [31:0] mt_next_word(input bit reseed);
        logic [31:0] word;
        if (reseed || !mt_seeded)
            refill_words();
        if (mt_pos >= MT_WORDS)
            twist_words();
        word = shape_word(mt_words[mt_pos]);
        mt_pos++;
        return word;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input bit reseed);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        push     <= 1'b1;
        i_reseed <= reseed;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
            n_full_cycles++;
        end
        pending_words.push_back(mt_next_word(reseed));
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        seed_shadow = value;
        n_seed_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_first_request();
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        wait_drained();
    endtask

    task automatic test_seed_extremes();
        logic [31:0] seeds [4];
        seeds = '{32'd5489, 32'hffff_ffff, 32'h0000_0000, 32'h8000_0001};
        foreach (seeds[s]) begin
            write_seed(seeds[s]);
            send_request(1'b0);
            send_request(1'b1);
            send_request(1'b0);
            wait_drained();
        end
        send_request(1'b1);
        send_request(1'b1);
        wait_drained();
    endtask

    task automatic test_twist_wrap();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        write_seed($urandom);
        send_request(1'b1);
        repeat (626) send_request(1'b0);
        wait_drained();
    endtask

    task automatic test_output_stall();
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        long_hold_req = 1'b1;
        @(negedge i_clk);
        repeat (16) send_request(1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < 60) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                write_seed($urandom);
            end
            src_idle_en  = 1'($urandom_range(0, 1));
            sink_idle_en = 1'($urandom_range(0, 1));
            burst        = int'($urandom_range(5, 20));
            repeat (burst) send_request($urandom_range(0, 15) == 0);
            sent += burst;
        end
        wait_drained();
    endtask

    task automatic test_no_idle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_seed($urandom);
        repeat (30) send_request($urandom_range(0, 15) == 0);
        wait_drained();
    endtask

    initial begin : result_sink
        wait (rst_done);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] exp_word;
        if (rst_done && pop && !empty) begin
            if (pending_words.size() == 0) begin
                err_count++;
                $display("%0t ERROR: unexpected transaction, expected none, actual %h",
                         $time, o_random_word);
            end else begin
                exp_word = pending_words.pop_front();
                n_checked++;
                if (o_random_word !== exp_word) begin
                    err_count++;
                    $display("%0t ERROR: random_word expected %h actual %h",
                             $time, exp_word, o_random_word);
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("%0t ERROR: timeout, %0d words still pending", $time, pending_words.size());
        $display("tb_mt19937_generator_top failed");
        $finish;
    end

    initial begin : main_seq
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_reseed    = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_seed  = 32'h0;
        seed_shadow = 32'h0;
        mt_pos      = MT_WORDS;
        mt_seeded   = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(negedge i_clk);

        test_first_request();
        test_seed_extremes();
        test_twist_wrap();
        test_output_stall();
        test_random_traffic();
        test_no_idle();

        wait_drained();
        repeat (50) @(negedge i_clk);
        $display("Covered %0d requests with %0d refills and %0d seed writes; %0d words checked.",
                 n_requests, n_refills, n_seed_writes, n_checked);
        $display("Input held off by full for %0d cycles; one output stall of %0d cycles.",
                 n_full_cycles, LONG_HOLD_CYCLES);
        if (err_count == 0) begin
            $display("tb_mt19937_generator_top passed");
        end else begin
            $display("tb_mt19937_generator_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
